// ===== hw/rtl/pid_clamping_antiwindup_assert.svh =====
// Assertion macros for the PID controller block.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef PID_CLAMPING_ANTIWINDUP_ASSERT_SVH
`define PID_CLAMPING_ANTIWINDUP_ASSERT_SVH

// same-cycle implication
`define PIDAW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pidaw: check failed");

// next-cycle implication
`define PIDAW_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pidaw: check failed");

`endif

// ===== hw/rtl/pidaw_pkg.sv =====
// Shared types and constants of the PID controller block.
// No dependencies.
package pidaw_pkg;

   localparam int GAIN_W    = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_LIMIT = 3'd4;

   // reset limits, truncated to the data width where they are used
   localparam logic signed [31:0] LOW_LIMIT_RESET  = -32'sd32768;
   localparam logic signed [31:0] HIGH_LIMIT_RESET = 32'sd32767;

   typedef enum logic [1:0] {
      SAT_NONE = 2'd0,
      SAT_HIGH = 2'd1,
      SAT_LOW  = 2'd2
   } sat_type;

endpackage

// ===== hw/rtl/pidaw_req_if.sv =====
// Error sample channel of the PID controller: valid/ready plus payload.
// No dependencies.
interface pidaw_req_if #(
   parameter int DATA_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] error_sample;

   modport source (output valid, output error_sample, input ready);
   modport sink   (input valid, input error_sample, output ready);
endinterface

// ===== hw/rtl/pidaw_rsp_if.sv =====
// Drive result channel of the PID controller: valid/ready plus payload.
// No dependencies.
interface pidaw_rsp_if #(
   parameter int DATA_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] drive;
   logic [1:0]                   sat_state;

   modport source (output valid, output drive, output sat_state, input ready);
   modport sink   (input valid, input drive, input sat_state, output ready);
endinterface

// ===== hw/rtl/pidaw_calc.sv =====
// PID update datapath: terms, sum, limit tests and integral anti-windup.
// Depends on pidaw_pkg.
module pidaw_calc
   import pidaw_pkg::*;
#(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic signed [DATA_WIDTH-1:0]           error_sample,
   input  logic signed [DATA_WIDTH-1:0]           last_error,
   input  logic signed [DATA_WIDTH+FRAC_BITS-1:0] integral,
   input  logic signed [GAIN_W-1:0]               prop_gain,
   input  logic signed [GAIN_W-1:0]               integ_gain,
   input  logic signed [GAIN_W-1:0]               deriv_gain,
   input  logic signed [DATA_WIDTH-1:0]           low_limit,
   input  logic signed [DATA_WIDTH-1:0]           high_limit,
   output logic signed [DATA_WIDTH-1:0]           drive,
   output sat_type                                sat,
   output logic signed [DATA_WIDTH+FRAC_BITS-1:0] integral_next
);
   localparam int INTEG_W = DATA_WIDTH + FRAC_BITS;
   localparam int PROD_W  = GAIN_W + DATA_WIDTH + 1;
   localparam int SUM_W   = PROD_W + 2;

   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

   logic signed [DATA_WIDTH:0]   diff;
   logic signed [PROD_W-1:0]     prop_term;
   logic signed [PROD_W-1:0]     deriv_term;
   logic signed [PROD_W-1:0]     integ_inc;
   logic signed [SUM_W-1:0]      sum;
   logic signed [SUM_W-1:0]      acc_raw;
   logic signed [INTEG_W-1:0]    acc_sat;
   logic signed [SUM_W-1:0]      low_q;
   logic signed [SUM_W-1:0]      high_q;

   assign diff       = (DATA_WIDTH+1)'(error_sample) - (DATA_WIDTH+1)'(last_error);
   assign prop_term  = PROD_W'(prop_gain) * PROD_W'(error_sample);
   assign deriv_term = PROD_W'(deriv_gain) * PROD_W'(diff);
   assign integ_inc  = PROD_W'(integ_gain) * PROD_W'(error_sample);

   assign sum     = SUM_W'(prop_term) + SUM_W'(integral) + SUM_W'(deriv_term);
   assign acc_raw = SUM_W'(integral) + SUM_W'(integ_inc);
   assign low_q   = SUM_W'(low_limit) <<< FRAC_BITS;
   assign high_q  = SUM_W'(high_limit) <<< FRAC_BITS;

   // integral saturates to its own width first
   always_comb begin
      if (acc_raw > SUM_W'(INTEG_MAX)) begin
         acc_sat = INTEG_MAX;
      end else if (acc_raw < SUM_W'(INTEG_MIN)) begin
         acc_sat = INTEG_MIN;
      end else begin
         acc_sat = acc_raw[INTEG_W-1:0];
      end
   end

   always_comb begin
      drive         = sum[FRAC_BITS +: DATA_WIDTH];
      sat           = SAT_NONE;
      integral_next = integral;
      if (sum > high_q) begin
         drive = high_limit;
         sat   = SAT_HIGH;
         // only a negative error may pull the integral out of saturation
         if (error_sample < 0) begin
            integral_next = acc_sat;
         end
      end else if (sum < low_q) begin
         drive = low_limit;
         sat   = SAT_LOW;
         if (error_sample > 0) begin
            integral_next = acc_sat;
         end
      end else if (SUM_W'(acc_sat) > high_q) begin
         integral_next = high_q[INTEG_W-1:0];
      end else if (SUM_W'(acc_sat) < low_q) begin
         integral_next = low_q[INTEG_W-1:0];
      end else begin
         integral_next = acc_sat;
      end
   end

endmodule

// ===== hw/rtl/pid_clamping_antiwindup.sv =====
// Positional PID controller with clamping anti-windup, top level.
// Depends on pidaw_pkg, pidaw_req_if, pidaw_rsp_if, pidaw_calc and the assert header.
//
// One error sample per transaction, one drive result per sample. A sample is
// captured in an input register, and the whole update (three products, the
// sum, the limit tests and the integral update) runs combinationally into the
// result register when the result channel is not stalled. A new sample can be
// taken every cycle while the result channel is not stalled. The integral and
// previous-error registers feed back through the update, which sets the rate.
// Gains are signed Q7.8, the integral carries FRAC_BITS fraction bits; reset
// clears the state, zeroes the gains and opens the limits. Write registers only
// while no sample is in flight.
module pid_clamping_antiwindup
   import pidaw_pkg::*;
#(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   pidaw_req_if.sink                  req_chan,
   pidaw_rsp_if.source                rsp_chan,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [((DATA_WIDTH > GAIN_W) ? DATA_WIDTH : GAIN_W)-1:0] csr_wdata
);
`include "pid_clamping_antiwindup_assert.svh"

   localparam int INTEG_W = DATA_WIDTH + FRAC_BITS;

   logic signed [GAIN_W-1:0]     prop_gain_ff, prop_gain_in;
   logic signed [GAIN_W-1:0]     integ_gain_ff, integ_gain_in;
   logic signed [GAIN_W-1:0]     deriv_gain_ff, deriv_gain_in;
   logic signed [DATA_WIDTH-1:0] low_limit_ff, low_limit_in;
   logic signed [DATA_WIDTH-1:0] high_limit_ff, high_limit_in;

   logic                         in_valid_ff, in_valid_in;
   logic signed [DATA_WIDTH-1:0] err_ff, err_in;
   logic                         out_valid_ff, out_valid_in;
   logic signed [DATA_WIDTH-1:0] drive_ff, drive_in;
   sat_type                      sat_ff, sat_in;
   logic signed [INTEG_W-1:0]    integ_ff, integ_in;
   logic signed [DATA_WIDTH-1:0] last_err_ff, last_err_in;

   logic                         advance;
   logic                         req_take;
   logic signed [DATA_WIDTH-1:0] calc_drive;
   sat_type                      calc_sat;
   logic signed [INTEG_W-1:0]    calc_integ;

   // ---- configuration registers
   always_comb begin
      prop_gain_in  = prop_gain_ff;
      integ_gain_in = integ_gain_ff;
      deriv_gain_in = deriv_gain_ff;
      low_limit_in  = low_limit_ff;
      high_limit_in = high_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_PROP_GAIN:  prop_gain_in  = csr_wdata[GAIN_W-1:0];
            REG_INTEG_GAIN: integ_gain_in = csr_wdata[GAIN_W-1:0];
            REG_DERIV_GAIN: deriv_gain_in = csr_wdata[GAIN_W-1:0];
            REG_LOW_LIMIT:  low_limit_in  = csr_wdata[DATA_WIDTH-1:0];
            REG_HIGH_LIMIT: high_limit_in = csr_wdata[DATA_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // ---- pipeline control: input register -> update -> result register
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   pidaw_calc #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_calc (
      .error_sample  (err_ff),
      .last_error    (last_err_ff),
      .integral      (integ_ff),
      .prop_gain     (prop_gain_ff),
      .integ_gain    (integ_gain_ff),
      .deriv_gain    (deriv_gain_ff),
      .low_limit     (low_limit_ff),
      .high_limit    (high_limit_ff),
      .drive         (calc_drive),
      .sat           (calc_sat),
      .integral_next (calc_integ)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      err_in       = err_ff;
      out_valid_in = out_valid_ff;
      drive_in     = drive_ff;
      sat_in       = sat_ff;
      integ_in     = integ_ff;
      last_err_in  = last_err_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         err_in      = req_chan.error_sample;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         drive_in     = calc_drive;
         sat_in       = calc_sat;
         integ_in     = calc_integ;
         last_err_in  = err_ff;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         deriv_gain_ff <= '0;
         low_limit_ff  <= LOW_LIMIT_RESET[DATA_WIDTH-1:0];
         high_limit_ff <= HIGH_LIMIT_RESET[DATA_WIDTH-1:0];
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         integ_ff      <= '0;
         last_err_ff   <= '0;
      end else begin
         prop_gain_ff  <= prop_gain_in;
         integ_gain_ff <= integ_gain_in;
         deriv_gain_ff <= deriv_gain_in;
         low_limit_ff  <= low_limit_in;
         high_limit_ff <= high_limit_in;
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         integ_ff      <= integ_in;
         last_err_ff   <= last_err_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      drive_ff <= drive_in;
      sat_ff   <= sat_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.drive     = drive_ff;
   assign rsp_chan.sat_state = sat_ff;

   // ---- checks
   `PIDAW_ASSERT_IMP(a_drive_in_window, clock, reset,
      out_valid_ff && (sat_ff == SAT_NONE),
      (drive_ff >= low_limit_ff) && (drive_ff <= high_limit_ff))
   `PIDAW_ASSERT_IMP(a_high_clamp, clock, reset,
      out_valid_ff && (sat_ff == SAT_HIGH), drive_ff == high_limit_ff)
   `PIDAW_ASSERT_IMP(a_low_clamp, clock, reset,
      out_valid_ff && (sat_ff == SAT_LOW), drive_ff == low_limit_ff)
   `PIDAW_ASSERT_NXT(a_state_holds, clock, reset,
      !advance, $stable(integ_ff) && $stable(last_err_ff))

endmodule
